// ===== hw/rtl/life_grid_generation_step_assert.svh =====
// assertion helpers shared by the grid step modules
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LGS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgs: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgs: next-cycle check failed");

`endif

// ===== hw/rtl/lgs_pkg.sv =====
package lgs_pkg;

   // grid store size
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ADDR_EXT_W = ROW_W + 2;

   // field widths
   localparam int CMD_W      = 2;
   localparam int POS_W      = 6;
   localparam int DIM_W      = 7;
   localparam int SUM_W      = DIM_W + 1;
   localparam int NB_W       = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [DIM_W-1:0] GRID_DIM_RESET = DIM_W'(64);

   // b3/s23 neighbor counts
   localparam logic [NB_W-1:0] BIRTH_COUNT   = NB_W'(3);
   localparam logic [NB_W-1:0] SURVIVE_COUNT = NB_W'(2);

   typedef logic [MAX_WIDTH-1:0] row_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } csr_reg_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic cell_write;
      logic step_prime;
      logic step_row;
      logic rsp_load;
   } lgs_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type req_cmd;
      logic    cell_go;
      logic    last_row;
   } lgs_status_type;

endpackage

// ===== hw/rtl/lgs_req_if.sv =====
interface lgs_req_if import lgs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [POS_W-1:0] start_x;
   logic [POS_W-1:0] start_y;
   logic [DIM_W-1:0] pattern_width;
   logic [DIM_W-1:0] pattern_height;
   logic [POS_W-1:0] offset_x;
   logic [POS_W-1:0] offset_y;
   logic             cell_value;

   modport source (
      output valid, cmd, start_x, start_y, pattern_width, pattern_height,
             offset_x, offset_y, cell_value,
      input  ready
   );

   modport sink (
      input  valid, cmd, start_x, start_y, pattern_width, pattern_height,
             offset_x, offset_y, cell_value,
      output ready
   );
endinterface

// ===== hw/rtl/lgs_rsp_if.sv =====
interface lgs_rsp_if import lgs_pkg::*; ();
   logic valid;
   logic ready;
   logic status;
   logic read_value;

   modport source (
      output valid, status, read_value,
      input  ready
   );

   modport sink (
      input  valid, status, read_value,
      output ready
   );
endinterface

// ===== hw/rtl/lgs_ctrl.sv =====
`include "life_grid_generation_step_assert.svh"

module lgs_ctrl import lgs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  lgs_status_type dp_status,
   output lgs_cmd_type    dp_cmd
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_CELL_WR    = 6'b000010,
      ST_CELL_RD    = 6'b000100,
      ST_FINISH     = 6'b001000,
      ST_STEP_PRIME = 6'b010000,
      ST_STEP_ROW   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (dp_status.req_cmd)
                  CMD_WRITE: state_in = dp_status.cell_go ? ST_CELL_WR : ST_FINISH;
                  CMD_READ:  state_in = ST_CELL_RD;
                  CMD_STEP:  state_in = ST_STEP_PRIME;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_CELL_WR:    state_in = ST_IDLE;
         ST_CELL_RD:    state_in = ST_IDLE;
         ST_FINISH:     state_in = ST_IDLE;
         ST_STEP_PRIME: state_in = ST_STEP_ROW;
         ST_STEP_ROW: begin
            if (dp_status.last_row) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.take       = take;
      dp_cmd.cell_write = (state_ff == ST_CELL_WR);
      dp_cmd.step_prime = (state_ff == ST_STEP_PRIME);
      dp_cmd.step_row   = (state_ff == ST_STEP_ROW);
      dp_cmd.rsp_load   = (state_ff == ST_CELL_WR) || (state_ff == ST_CELL_RD) ||
                          (state_ff == ST_FINISH) ||
                          ((state_ff == ST_STEP_ROW) && dp_status.last_row);
   end

   assign rsp_valid_in = dp_cmd.rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LGS_ASSERT_NEXT(a_take_leaves_idle, clock, reset, take, state_ff != ST_IDLE)
   `LGS_ASSERT_HOLDS(a_load_into_empty, clock, reset, dp_cmd.rsp_load, !rsp_valid_ff)
   `LGS_ASSERT_NEXT(a_step_end_responds, clock, reset, (state_ff == ST_STEP_ROW) && dp_status.last_row, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

// ===== hw/rtl/lgs_datapath.sv =====
`include "life_grid_generation_step_assert.svh"

module lgs_datapath import lgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [POS_W-1:0]      req_start_x,
   input  logic [POS_W-1:0]      req_start_y,
   input  logic [DIM_W-1:0]      req_pattern_width,
   input  logic [DIM_W-1:0]      req_pattern_height,
   input  logic [POS_W-1:0]      req_offset_x,
   input  logic [POS_W-1:0]      req_offset_y,
   input  logic                  req_cell_value,
   input  lgs_cmd_type           dp_cmd,
   output lgs_status_type        dp_status,
   output logic                  rsp_status,
   output logic                  rsp_read_value
);

   function automatic logic pattern_fits(
      input logic [POS_W-1:0] sx,
      input logic [POS_W-1:0] sy,
      input logic [DIM_W-1:0] pw,
      input logic [DIM_W-1:0] ph,
      input logic [POS_W-1:0] ox,
      input logic [POS_W-1:0] oy,
      input logic [DIM_W-1:0] w,
      input logic [DIM_W-1:0] h
   );
      logic [SUM_W-1:0] ex;
      logic [SUM_W-1:0] ey;
      ex = SUM_W'(sx) + SUM_W'(pw);
      ey = SUM_W'(sy) + SUM_W'(ph);
      return (ex <= SUM_W'(w)) && (ey <= SUM_W'(h)) &&
             (DIM_W'(ox) < pw) && (DIM_W'(oy) < ph);
   endfunction

   // configuration
   logic [DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [DIM_W-1:0] grid_height_ff, grid_height_in;
   logic [DIM_W-1:0] w_eff, h_eff;
   row_type          col_mask;

   // latched request
   cmd_type          cmd_ff;
   logic [POS_W-1:0] sx_ff, sy_ff, ox_ff, oy_ff;
   logic [DIM_W-1:0] pw_ff, ph_ff;
   logic             val_ff;

   // grid store
   row_type          grid_mem [MAX_HEIGHT];
   logic [MAX_HEIGHT-1:0] row_valid_ff;
   row_type          rd_row_ff;
   logic             rd_valid_ff;
   logic [ADDR_EXT_W-1:0] raddr_ext;
   logic [ROW_W-1:0] raddr, waddr;
   logic             mem_re, mem_we;
   row_type          wdata;

   // sweep window
   row_type          above_ff, above_in;
   row_type          cur_ff, cur_in;
   logic [ROW_W-1:0] row_ff, row_in;
   row_type          rd_masked;
   row_type          new_row;
   logic             rd_in_grid;
   logic             cur_in_grid;

   logic [DIM_W-1:0] cell_row;
   logic [COL_W-1:0] cell_col;
   logic             read_inside;
   logic             status_in, read_value_in;
   logic             rsp_status_ff, rsp_read_value_ff;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_wdata;
            REG_GRID_HEIGHT: grid_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_DIM_RESET;
         grid_height_ff <= GRID_DIM_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // saturate to 1..max
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (int'(grid_width_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (int'(grid_height_ff) > MAX_HEIGHT) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = grid_height_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         col_mask[i] = (i < int'(w_eff));
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.take) begin
         cmd_ff <= cmd_type'(req_cmd);
         sx_ff  <= req_start_x;
         sy_ff  <= req_start_y;
         pw_ff  <= req_pattern_width;
         ph_ff  <= req_pattern_height;
         ox_ff  <= req_offset_x;
         oy_ff  <= req_offset_y;
         val_ff <= req_cell_value;
      end
   end

   always_comb begin
      dp_status.req_cmd  = cmd_type'(req_cmd);
      dp_status.cell_go  = (cmd_type'(req_cmd) == CMD_WRITE) && req_cell_value &&
                           pattern_fits(req_start_x, req_start_y, req_pattern_width,
                                        req_pattern_height, req_offset_x, req_offset_y,
                                        w_eff, h_eff);
      dp_status.last_row = (row_ff == ROW_W'(MAX_HEIGHT - 1));
   end

   assign cell_row = DIM_W'(sy_ff) + DIM_W'(oy_ff);
   assign cell_col = COL_W'(DIM_W'(sx_ff) + DIM_W'(ox_ff));

   // read address: request row on take, then rows ahead of the sweep
   always_comb begin
      raddr_ext = '0;
      if (dp_cmd.take) begin
         case (cmd_type'(req_cmd))
            CMD_WRITE: raddr_ext = ADDR_EXT_W'(DIM_W'(req_start_y) + DIM_W'(req_offset_y));
            CMD_READ:  raddr_ext = ADDR_EXT_W'(req_start_y);
            default:   raddr_ext = '0;
         endcase
      end else if (dp_cmd.step_prime) begin
         raddr_ext = ADDR_EXT_W'(row_ff) + ADDR_EXT_W'(1);
      end else if (dp_cmd.step_row) begin
         raddr_ext = ADDR_EXT_W'(row_ff) + ADDR_EXT_W'(2);
      end
   end

   assign mem_re = (dp_cmd.take || dp_cmd.step_prime || dp_cmd.step_row) &&
                   (int'(raddr_ext) < MAX_HEIGHT);
   assign raddr  = raddr_ext[ROW_W-1:0];

   always_comb begin
      mem_we = dp_cmd.cell_write || dp_cmd.step_row;
      if (dp_cmd.cell_write) begin
         waddr = ROW_W'(cell_row);
         wdata = (rd_valid_ff ? rd_row_ff : '0) | (row_type'(1) << cell_col);
      end else begin
         waddr = row_ff;
         wdata = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_row_ff <= grid_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            row_valid_ff[waddr] <= 1'b1;
         end
         rd_valid_ff <= mem_re && row_valid_ff[raddr];
      end
   end

   // row that arrived from the store, dead outside the grid in use
   assign rd_in_grid  = (int'(row_ff) + (dp_cmd.step_row ? 1 : 0)) < int'(h_eff);
   assign cur_in_grid = int'(row_ff) < int'(h_eff);
   assign rd_masked   = rd_row_ff & col_mask & {MAX_WIDTH{rd_valid_ff && rd_in_grid}};

   always_comb begin
      logic [MAX_WIDTH+1:0] ap;
      logic [MAX_WIDTH+1:0] cp;
      logic [MAX_WIDTH+1:0] bp;
      logic [NB_W-1:0]      nb;
      ap = {1'b0, above_ff, 1'b0};
      cp = {1'b0, cur_ff, 1'b0};
      bp = {1'b0, rd_masked, 1'b0};
      for (int x = 0; x < MAX_WIDTH; x++) begin
         nb = NB_W'(ap[x]) + NB_W'(ap[x+1]) + NB_W'(ap[x+2]) +
              NB_W'(cp[x]) + NB_W'(cp[x+2]) +
              NB_W'(bp[x]) + NB_W'(bp[x+1]) + NB_W'(bp[x+2]);
         new_row[x] = ((nb == BIRTH_COUNT) || ((nb == SURVIVE_COUNT) && cur_ff[x])) &&
                      col_mask[x] && cur_in_grid;
      end
   end

   always_comb begin
      above_in = above_ff;
      cur_in   = cur_ff;
      row_in   = row_ff;
      if (dp_cmd.take) begin
         above_in = '0;
         row_in   = '0;
      end else if (dp_cmd.step_prime) begin
         cur_in   = rd_masked;
      end else if (dp_cmd.step_row) begin
         above_in = cur_ff;
         cur_in   = rd_masked;
         row_in   = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      above_ff <= above_in;
      cur_ff   <= cur_in;
      row_ff   <= row_in;
   end

   assign read_inside = (int'(sx_ff) < int'(w_eff)) && (int'(sy_ff) < int'(h_eff));

   always_comb begin
      status_in     = ((cmd_ff == CMD_WRITE) &&
                       !pattern_fits(sx_ff, sy_ff, pw_ff, ph_ff, ox_ff, oy_ff,
                                     w_eff, h_eff)) ||
                      ((cmd_ff == CMD_READ) && !read_inside);
      read_value_in = (cmd_ff == CMD_READ) && read_inside && rd_valid_ff &&
                      rd_row_ff[COL_W'(sx_ff)];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.rsp_load) begin
         rsp_status_ff     <= status_in;
         rsp_read_value_ff <= read_value_in;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;

   `LGS_ASSERT_HOLDS(a_cell_row_in_grid, clock, reset, dp_cmd.cell_write, (int'(cell_row) < int'(h_eff)) && val_ff)
   `LGS_ASSERT_HOLDS(a_step_cols_clear, clock, reset, dp_cmd.step_row, (new_row & ~col_mask) == '0)

endmodule

// ===== hw/rtl/life_grid_generation_step.sv =====
// sequencing: cell write and cell read pass their own state, the unused command the finish
//   state, then the result register loads; a generation step runs the prime state, then the
//   row state for every store row (row-serial sweep); a new transaction is taken only after
//   the last loads its result; the row store takes one row read and one row write a cycle
// reset: synchronous, active high; grid width and height return to 64 and per-row valid
//   bits clear so the whole grid reads dead at once, with no clearing pass
`include "life_grid_generation_step_assert.svh"

module life_grid_generation_step import lgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   lgs_req_if.sink               req_if,
   lgs_rsp_if.source             rsp_if
);

   // control and status between the sequencer and the datapath
   lgs_cmd_type    dp_cmd;
   lgs_status_type dp_status;

   logic req_ready;
   logic rsp_valid;
   logic rsp_status;
   logic rsp_read_value;

   // sequencer: one transaction at a time
   //   idle -> cell write (read-modify-write of one row)
   //   idle -> cell read (one row read, pick the column)
   //   idle -> step prime -> step row x MAX_HEIGHT (in-place sweep, three-row window)
   //   idle -> finish for pattern errors, dead-value writes and the unused command
   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // datapath: grid registers, row store with valid bits, sweep window with
   // a full row of neighbor counters, result register
   lgs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cmd            (req_if.cmd),
      .req_start_x        (req_if.start_x),
      .req_start_y        (req_if.start_y),
      .req_pattern_width  (req_if.pattern_width),
      .req_pattern_height (req_if.pattern_height),
      .req_offset_x       (req_if.offset_x),
      .req_offset_y       (req_if.offset_y),
      .req_cell_value     (req_if.cell_value),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value)
   );

   // request side is ready only while idle with the result register free or draining
   assign req_if.ready = req_ready;

   // result register drives the response channel directly
   assign rsp_if.valid      = rsp_valid;
   assign rsp_if.status     = rsp_status;
   assign rsp_if.read_value = rsp_read_value;

   // a response only appears after a request transaction was taken
   `LGS_ASSERT_NEXT(a_rsp_follows_take, clock, reset, !rsp_valid && !(req_if.valid && req_ready) && !dp_cmd.rsp_load, !rsp_valid)

endmodule
